// File: rtl/tdpt_pkg.sv
`timescale 1ns / 1ps

package tdpt_pkg;

  // first trial divisor
  localparam int unsigned DivisorStart = 2;

  // status of the shared divider as seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// File: rtl/tdpt_div.sv
`timescale 1ns / 1ps

module tdpt_div #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [VALUE_WIDTH-1:0]   dividend_i,
  input  logic [VALUE_WIDTH-1:0]   divisor_i,
  output tdpt_pkg::div_status_t    status_o,
  output logic [VALUE_WIDTH-1:0]   quotient_o,
  output logic [VALUE_WIDTH-1:0]   remainder_o
);

  localparam int unsigned CntW = $clog2(VALUE_WIDTH + 1);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] rem_q, rem_d;
  logic [VALUE_WIDTH-1:0] quo_q, quo_d;
  logic [VALUE_WIDTH-1:0] dvs_q, dvs_d;

  // one restoring step: shift in the next dividend bit and try a subtract
  logic [VALUE_WIDTH:0]   shifted;
  logic [VALUE_WIDTH:0]   diff;

  assign shifted = {rem_q, quo_q[VALUE_WIDTH-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(VALUE_WIDTH);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[VALUE_WIDTH]) begin
        rem_d = diff[VALUE_WIDTH-1:0];
        quo_d = {quo_q[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem_d = shifted[VALUE_WIDTH-1:0];
        quo_d = {quo_q[VALUE_WIDTH-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = quo_q;
  assign remainder_o   = rem_q;

endmodule

// File: rtl/trial_division_prime_test_top.sv
`timescale 1ns / 1ps
// sequence: candidates 0 and 1 go straight to the finish state; otherwise the
//   bit-serial shared divider runs once per trial divisor, up to k, the last
//   divisor tried (at most floor(sqrt(candidate)) + 1)
// throughput: one item at a time; the next item is taken once the result
//   is in the output register
// reset: asynchronous active low, clears the sequencer and the output valid

module trial_division_prime_test_top #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] candidate
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] candidate_echo
  output logic        m_axis_tuser_o    // [0] is_prime_flag
);

  typedef enum logic [1:0] {
    StIdle,
    StStart,
    StWait,
    StFinish
  } state_e;

  state_e                  state_q;
  logic [VALUE_WIDTH-1:0]  n_q;
  logic [VALUE_WIDTH-1:0]  d_q;
  logic                    prime_q;
  logic                    out_valid_q;
  logic                    out_flag_q;
  logic [31:0]             out_echo_q;

  logic [VALUE_WIDTH-1:0]  cand_ext;
  logic [31:0]             n_echo;
  logic                    div_start;
  tdpt_pkg::div_status_t   div_status;
  logic [VALUE_WIDTH-1:0]  div_quo;
  logic [VALUE_WIDTH-1:0]  div_rem;
  logic                    out_free;

  // fit the candidate to the datapath width and the echo back to 32 bits
  if (VALUE_WIDTH > 32) begin : g_wide
    assign cand_ext = {{(VALUE_WIDTH-32){1'b0}}, s_axis_tdata_i};
    assign n_echo   = n_q[31:0];
  end else if (VALUE_WIDTH == 32) begin : g_exact
    assign cand_ext = s_axis_tdata_i;
    assign n_echo   = n_q;
  end else begin : g_narrow
    assign cand_ext = s_axis_tdata_i[VALUE_WIDTH-1:0];
    assign n_echo   = {{(32-VALUE_WIDTH){1'b0}}, n_q};
  end

  // shared divider computes n / d and n % d for each trial
  tdpt_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (n_q),
    .divisor_i  (d_q),
    .status_o   (div_status),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  assign div_start       = (state_q == StStart);
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == StIdle);

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      n_q         <= '0;
      d_q         <= '0;
      prime_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_flag_q  <= 1'b0;
      out_echo_q  <= '0;
    end else begin
      // finish state reloads the output register itself
      if (out_valid_q && m_axis_tready_i && (state_q != StFinish)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (s_axis_tvalid_i) begin
            n_q <= cand_ext;
            d_q <= VALUE_WIDTH'(tdpt_pkg::DivisorStart);
            if (cand_ext < VALUE_WIDTH'(tdpt_pkg::DivisorStart)) begin
              prime_q <= 1'b0;
              state_q <= StFinish;
            end else begin
              state_q <= StStart;
            end
          end
        end
        StStart: begin
          state_q <= StWait;
        end
        StWait: begin
          if (div_status.done) begin
            if (d_q > div_quo) begin
              // divisor squared now exceeds the candidate
              prime_q <= 1'b1;
              state_q <= StFinish;
            end else if (div_rem == '0) begin
              prime_q <= 1'b0;
              state_q <= StFinish;
            end else begin
              d_q     <= d_q + VALUE_WIDTH'(1);
              state_q <= StStart;
            end
          end
        end
        StFinish: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_flag_q  <= prime_q;
            out_echo_q  <= n_echo;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_echo_q;
  assign m_axis_tuser_o  = out_flag_q;

  // divider is only started when it is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_status.busy)
    else $error("divider started while busy");

  // trial divisors never drop below the first one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWait) |-> (d_q >= VALUE_WIDTH'(tdpt_pkg::DivisorStart)))
    else $error("trial divisor below start value");

  // an accepted item closes the input until its result is posted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input reopened right after accept");

  // a value reported prime is at least two
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |->
      ((VALUE_WIDTH > 32) || (m_axis_tdata_o >= 32'd2)))
    else $error("value below two reported prime");

endmodule
